/* src/lfsa_pkg.sv */
`default_nettype none

package lfsa_pkg;

    // Default number of resource slots
    localparam int SLOTS_DEF = 64;

    // Fixed field widths
    localparam int TIME_W = 32;
    localparam int USES_W = 16;

    // Saturation value of a slot's use count
    localparam logic [USES_W-1:0] USES_MAX = {USES_W{1'b1}};

endpackage

`default_nettype wire

/* src/lfsa_if.sv */
`default_nettype none

// Request channel: one occupancy request per item
interface lfsa_req_if #(
    parameter int TW = lfsa_pkg::TIME_W
);
    logic          valid;
    logic          ready;
    logic [TW-1:0] start_time;
    logic [TW-1:0] end_time;

    modport source (output valid, output start_time, output end_time, input ready);
    modport sink   (input valid, input start_time, input end_time, output ready);
endinterface

// Result channel: one allocation result per item
interface lfsa_res_if #(
    parameter int SW = 6,
    parameter int OW = 7,
    parameter int UW = lfsa_pkg::USES_W
);
    logic          valid;
    logic          ready;
    logic [SW-1:0] slot;
    logic [UW-1:0] slot_uses;
    logic [OW-1:0] slots_opened;
    logic          overflow;

    modport source (output valid, output slot, output slot_uses, output slots_opened,
                    output overflow, input ready);
    modport sink   (input valid, input slot, input slot_uses, input slots_opened,
                    input overflow, output ready);
endinterface

`default_nettype wire

/* src/lowest_free_slot_interval_allocator_unit.sv */
`default_nettype none

// Channel  | Dir | Fields                                        | Handshake
// ---------+-----+-----------------------------------------------+------------
// i_req    | in  | start_time[31:0], end_time[31:0]              | valid/ready
// o_res    | out | slot, slot_uses[15:0], slots_opened, overflow | valid/ready
//
// From acceptance, an item scans the opened slots (opened, the number of slots opened so
// far, is at most SLOTS) until its result loads; the scan reads
// one slot per cycle from the single-port busy-until/use-count memory, in order,
// and the next item can be taken in the cycle after the result loads.
// Reset (i_rst_n low, synchronous) clears the sequencer, the opened count and
// the result valid; no memory clearing pass is needed, only opened slots are read.
// i_req.ready is high only while idle; a stalled result holds the commit step.

module lowest_free_slot_interval_allocator_unit #(
    parameter int SLOTS = lfsa_pkg::SLOTS_DEF,
    parameter int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1,
    parameter int CW    = $clog2(SLOTS + 1)
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    lfsa_req_if.sink     i_req,
    lfsa_res_if.source   o_res
);

    localparam int TW = lfsa_pkg::TIME_W;
    localparam int UW = lfsa_pkg::USES_W;

    // Sequencer codes
    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_COMMIT = 2'd2;

    // Slot memories
    logic [TW-1:0] busy_mem [SLOTS];
    logic [UW-1:0] uses_mem [SLOTS];

    // Control state
    logic [1:0]    r_state,   n_state;
    logic [CW-1:0] r_idx,     n_idx;
    logic          r_q_vld,   n_q_vld;
    logic [CW-1:0] r_opened,  n_opened;
    logic          r_out_vld, n_out_vld;

    // Payload registers
    logic [TW-1:0] r_start;
    logic [TW-1:0] r_end;
    logic [TW-1:0] r_busy_q;
    logic [UW-1:0] r_uses_q;
    logic [SW-1:0] r_q_idx;
    logic [SW-1:0] r_pick;
    logic [UW-1:0] r_uses_new;
    logic          r_is_new;
    logic          r_ovf;
    logic [SW-1:0] r_o_slot;
    logic [UW-1:0] r_o_uses;
    logic [CW-1:0] r_o_opened;
    logic          r_o_ovf;

    logic in_fire;
    logic out_fire;
    logic issue;
    logic hit;
    logic miss;
    logic full;
    logic commit;

    assign i_req.ready        = (r_state == S_IDLE);
    assign o_res.valid        = r_out_vld;
    assign o_res.slot         = r_o_slot;
    assign o_res.slot_uses    = r_o_uses;
    assign o_res.slots_opened = r_o_opened;
    assign o_res.overflow     = r_o_ovf;

    // Decode handshakes and scan events
    always_comb begin
        in_fire  = i_req.valid && i_req.ready;
        out_fire = o_res.valid && o_res.ready;
        issue    = (r_state == S_SCAN) && (r_idx < r_opened);
        hit      = (r_state == S_SCAN) && r_q_vld && (r_busy_q <= r_start);
        miss     = (r_state == S_SCAN) && !r_q_vld && (r_idx == r_opened);
        full     = (r_opened == CW'(SLOTS));
        commit   = (r_state == S_COMMIT) && (!r_out_vld || o_res.ready);
    end

    // Sequence the scan
    always_comb begin
        n_state   = r_state;
        n_idx     = r_idx;
        n_q_vld   = 1'b0;
        n_opened  = r_opened;
        n_out_vld = r_out_vld;
        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_state = S_SCAN;
                    n_idx   = '0;
                end
            end
            S_SCAN: begin
                if (hit || miss) begin
                    n_state = S_COMMIT;
                end else if (issue) begin
                    n_idx   = r_idx + CW'(1);
                    n_q_vld = 1'b1;
                end
            end
            S_COMMIT: begin
                if (commit) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (commit && r_is_new && !r_ovf) begin
            n_opened = r_opened + CW'(1);
        end
        if (commit) begin
            n_out_vld = 1'b1;
        end else if (out_fire) begin
            n_out_vld = 1'b0;
        end
    end

    // Hold control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_idx     <= '0;
            r_q_vld   <= 1'b0;
            r_opened  <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_idx     <= n_idx;
            r_q_vld   <= n_q_vld;
            r_opened  <= n_opened;
            r_out_vld <= n_out_vld;
        end
    end

    // Capture the request item
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_start <= i_req.start_time;
            r_end   <= i_req.end_time;
        end
    end

    // Read one opened slot per cycle
    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_busy_q <= busy_mem[r_idx[SW-1:0]];
            r_uses_q <= uses_mem[r_idx[SW-1:0]];
            r_q_idx  <= r_idx[SW-1:0];
        end
    end

    // Latch the chosen slot: first free opened slot, else the next unopened one, else slot 0 with overflow
    always_ff @(posedge i_clk) begin
        if (hit) begin
            r_pick     <= r_q_idx;
            r_uses_new <= (r_uses_q == lfsa_pkg::USES_MAX) ? r_uses_q
                                                           : r_uses_q + UW'(1);
            r_is_new   <= 1'b0;
            r_ovf      <= 1'b0;
        end else if (miss) begin
            r_pick     <= full ? '0 : r_opened[SW-1:0];
            r_uses_new <= full ? '0 : UW'(1);
            r_is_new   <= !full;
            r_ovf      <= full;
        end
    end

    // Write back the slot unless every slot was busy
    always_ff @(posedge i_clk) begin
        if (commit && !r_ovf) begin
            busy_mem[r_pick] <= r_end;
            uses_mem[r_pick] <= r_uses_new;
        end
    end

    // Load the result register
    always_ff @(posedge i_clk) begin
        if (commit) begin
            r_o_slot   <= r_pick;
            r_o_uses   <= r_uses_new;
            r_o_opened <= n_opened;
            r_o_ovf    <= r_ovf;
        end
    end

endmodule

`default_nettype wire
